// ===== rtl/rodrigues_rotation_tensor_defines.svh =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RODRIGUES_ROTATION_TENSOR_DEFINES_SVH
`define RODRIGUES_ROTATION_TENSOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RRT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor package
// Widths, constants and shared types of the rotation and tensor pipelines.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int unsigned RodW    = 21;  // Rodrigues component, Q16
  localparam int unsigned FracW   = 16;
  localparam int unsigned ProdW   = 2 * RodW;
  localparam int unsigned NumW    = ProdW + 1;  // numerators and 1 + s
  localparam int unsigned DsrW    = NumW;       // divisor 2 * (1 + s)
  localparam int unsigned QBits   = FracW + 2;  // biased quotient bits
  localparam int unsigned DivW    = NumW + FracW + 2;
  localparam int unsigned RotW    = 18;
  localparam int unsigned DiffW   = 32;
  localparam int unsigned TenW    = 33;
  localparam int unsigned RowW    = 2;
  localparam int unsigned NumEnt  = 9;
  localparam int unsigned FrontStg = 3;
  localparam int unsigned TenStg  = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned InBits     = 3 * RodW;
  localparam int unsigned InTdataW   = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits    = RowW + 3 * RotW + 3 * TenW;
  localparam int unsigned OutTdataW  = ((OutBits + 7) / 8) * 8;

  localparam longint OneQ32    = 64'sd4294967296;
  localparam longint RoundHalf = 64'sd2147483648;
  localparam longint TenLimit  = 64'sd4294967295;
  localparam int     RotOne    = 65536;

  localparam logic [RowW-1:0] ROW_FIRST = 2'd0;
  localparam logic [RowW-1:0] ROW_LAST  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_DIFF_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIFF_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIFF_Z = 2'd2;

  // Full rotation matrix of one grain, rot[row][col], signed Q16.
  typedef struct packed {
    logic                         last_grain;
    logic [2:0][2:0][RotW-1:0]    rot;
  } rot_item_t;

  // Side information that travels with one row through the tensor stages.
  typedef struct packed {
    logic [RowW-1:0]         row;
    logic [2:0][RotW-1:0]    rot;
    logic                    last_row;
    logic                    batch_end;
  } row_meta_t;

endpackage

// ===== rtl/rrt_divider.sv =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor divider
// Nine-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rrt_divider (
  input  logic                                             clk_i,
  input  logic [rrt_pkg::QBits-1:0]                        en_i,
  input  logic [rrt_pkg::NumEnt-1:0][rrt_pkg::DivW-1:0]    dvd_i,
  input  logic [rrt_pkg::DsrW-1:0]                         dsr_i,
  output logic [rrt_pkg::NumEnt-1:0][rrt_pkg::QBits-1:0]   quo_o
);
  import rrt_pkg::*;

  logic [QBits-1:0][NumEnt-1:0][DivW-1:0]  rem_q;
  logic [QBits-1:0][NumEnt-1:0][QBits-1:0] quo_q;
  logic [QBits-1:0][DsrW-1:0]              dsr_q;

  for (genvar k = 0; k < QBits; k++) begin : g_step
    logic [NumEnt-1:0][DivW-1:0]  rem_in, rem_d;
    logic [NumEnt-1:0][QBits-1:0] quo_in, quo_d;
    logic [DsrW-1:0]              dsr_in;
    logic [DivW-1:0]              sub;

    if (k == 0) begin : g_first
      assign rem_in = dvd_i;
      assign quo_in = '0;
      assign dsr_in = dsr_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dsr_in = dsr_q[k-1];
    end

    // Divisor aligned to the quotient bit that this stage settles.
    assign sub = DivW'(dsr_in) << (QBits - 1 - k);

    always_comb begin
      for (int e = 0; e < NumEnt; e++) begin
        if (rem_in[e] >= sub) begin
          rem_d[e] = rem_in[e] - sub;
          quo_d[e] = {quo_in[e][QBits-2:0], 1'b1};
        end else begin
          rem_d[e] = rem_in[e];
          quo_d[e] = {quo_in[e][QBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        dsr_q[k] <= dsr_in;
      end
    end
  end

  assign quo_o = quo_q[QBits-1];

endmodule

// ===== rtl/rrt_rot_pipe.sv =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor rotation pipeline
// Products, numerators and the divider that give the full rotation matrix.
// ----------------------------------------------------------------------------
module rrt_rot_pipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [rrt_pkg::RodW-1:0]   rod_x_i,
  input  logic signed [rrt_pkg::RodW-1:0]   rod_y_i,
  input  logic signed [rrt_pkg::RodW-1:0]   rod_z_i,
  input  logic                              last_grain_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rrt_pkg::rot_item_t                out_item_o
);
  import rrt_pkg::*;

  localparam int unsigned NStg = FrontStg + QBits;

  logic [NStg-1:0] vld_q, vld_src, stg_rdy, last_q, last_src;

  // Each stage takes a new word when it is empty or its successor moves.
  for (genvar k = 0; k < NStg; k++) begin : g_rdy
    if (k == NStg - 1) begin : g_tail
      assign stg_rdy[k] = !vld_q[k] || out_ready_i;
    end else begin : g_body
      assign stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign vld_src  = {vld_q[NStg-2:0], in_valid_i};
  assign last_src = {last_q[NStg-2:0], last_grain_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (stg_rdy[k]) begin
          vld_q[k] <= vld_src[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (stg_rdy[k]) begin
        last_q[k] <= last_src[k];
      end
    end
  end

  // Stage 0: the six component products, exact in Q32.
  logic signed [ProdW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q;
  logic signed [RodW-1:0]  rx_q, ry_q, rz_q;

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      xx_q <= rod_x_i * rod_x_i;
      yy_q <= rod_y_i * rod_y_i;
      zz_q <= rod_z_i * rod_z_i;
      xy_q <= rod_x_i * rod_y_i;
      xz_q <= rod_x_i * rod_z_i;
      yz_q <= rod_y_i * rod_z_i;
      rx_q <= rod_x_i;
      ry_q <= rod_y_i;
      rz_q <= rod_z_i;
    end
  end

  // Stage 1: numerators of all nine entries and d = 1 + s.
  logic signed [NumEnt-1:0][NumW-1:0] num_d, num_q;
  logic        [NumW-1:0]             dd_d, dd_q;

  always_comb begin
    logic signed [NumW-1:0] one, xx, yy, zz, xy, xz, yz, xs, ys, zs;
    one = NumW'(OneQ32);
    xx  = NumW'(xx_q);
    yy  = NumW'(yy_q);
    zz  = NumW'(zz_q);
    xy  = NumW'(xy_q);
    xz  = NumW'(xz_q);
    yz  = NumW'(yz_q);
    xs  = NumW'(rx_q) <<< FracW;
    ys  = NumW'(ry_q) <<< FracW;
    zs  = NumW'(rz_q) <<< FracW;
    dd_d     = one + xx + yy + zz;
    num_d[0] = one + xx - yy - zz;
    num_d[1] = (xy - zs) <<< 1;
    num_d[2] = (xz + ys) <<< 1;
    num_d[3] = (xy + zs) <<< 1;
    num_d[4] = one - xx + yy - zz;
    num_d[5] = (yz - xs) <<< 1;
    num_d[6] = (xz - ys) <<< 1;
    num_d[7] = (yz + xs) <<< 1;
    num_d[8] = one - xx - yy + zz;
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[1]) begin
      num_q <= num_d;
      dd_q  <= dd_d;
    end
  end

  // Stage 2: biased dividend ((num + d) * 2^17 + d) and divisor 2d. The bias
  // keeps the dividend positive, so the quotient is the entry plus one.
  logic [NumEnt-1:0][DivW-1:0] dvd_d, dvd_q;
  logic [DsrW-1:0]             dsr_q;

  always_comb begin
    logic [NumW-1:0] npd;
    for (int e = 0; e < NumEnt; e++) begin
      npd      = num_q[e] + dd_q;
      dvd_d[e] = (DivW'(npd) << (FracW + 1)) + DivW'(dd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[2]) begin
      dvd_q <= dvd_d;
      dsr_q <= DsrW'(dd_q) << 1;
    end
  end

  logic [NumEnt-1:0][QBits-1:0] quo;

  rrt_divider u_div (
    .clk_i (clk_i),
    .en_i  (stg_rdy[NStg-1:FrontStg]),
    .dvd_i (dvd_q),
    .dsr_i (dsr_q),
    .quo_o (quo)
  );

  // Remove the bias and saturate to plus or minus one.
  always_comb begin
    logic signed [RotW:0] unb;
    out_item_o.last_grain = last_q[NStg-1];
    for (int e = 0; e < NumEnt; e++) begin
      unb = $signed({1'b0, quo[e]}) - (RotW + 1)'(RotOne);
      if (unb > (RotW + 1)'(RotOne)) begin
        out_item_o.rot[e / 3][e % 3] = RotW'(RotOne);
      end else begin
        out_item_o.rot[e / 3][e % 3] = unb[RotW-1:0];
      end
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign in_ready_o  = stg_rdy[0];

endmodule

// ===== rtl/rrt_tensor_pipe.sv =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor row pipeline
// Row sequencer and the R * diag(D) * R^T stages with the output register.
// ----------------------------------------------------------------------------
`include "rodrigues_rotation_tensor_defines.svh"

module rrt_tensor_pipe (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  rrt_pkg::rot_item_t                             in_item_i,
  input  logic [2:0][rrt_pkg::DiffW-1:0]                 diff_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output rrt_pkg::row_meta_t                             out_meta_o,
  output logic [2:0][rrt_pkg::TenW-1:0]                  out_ten_o
);
  import rrt_pkg::*;

  localparam int unsigned PW    = 2 * RotW;
  localparam int unsigned PartW = PW + FracW + 1;
  localparam int unsigned SumW  = PartW + 2;
  localparam int unsigned AccW  = SumW + FracW + 1;
  localparam int unsigned TW    = AccW - 2 * FracW;

  // Row sequencer: holds one matrix and hands out its three rows.
  logic            busy_q;
  logic [RowW-1:0] row_q;
  rot_item_t       item_q;
  logic            job_acc;

  logic [TenStg-1:0] vld_q, vld_src, stg_rdy;
  row_meta_t [TenStg-1:0] meta_q;
  row_meta_t              meta_src;

  assign job_acc    = busy_q && stg_rdy[0];
  assign in_ready_o = !busy_q || (job_acc && (row_q == ROW_LAST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= ROW_FIRST;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
      row_q  <= ROW_FIRST;
    end else if (job_acc) begin
      row_q <= RowW'(row_q + 1'b1);
      if (row_q == ROW_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  for (genvar k = 0; k < TenStg; k++) begin : g_rdy
    if (k == TenStg - 1) begin : g_tail
      assign stg_rdy[k] = !vld_q[k] || out_ready_i;
    end else begin : g_body
      assign stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign vld_src = {vld_q[TenStg-2:0], busy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < TenStg; k++) begin
        if (stg_rdy[k]) begin
          vld_q[k] <= vld_src[k];
        end
      end
    end
  end

  always_comb begin
    meta_src.row       = row_q;
    meta_src.rot       = item_q.rot[row_q];
    meta_src.last_row  = (row_q == ROW_LAST);
    meta_src.batch_end = (row_q == ROW_LAST) && item_q.last_grain;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TenStg; k++) begin
      if (stg_rdy[k]) begin
        meta_q[k] <= (k == 0) ? meta_src : meta_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Stage 0: p[j][k] = R[i][k] * R[j][k].
  logic signed [PW-1:0] p_q [3][3];

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          p_q[j][k] <= PW'($signed(meta_src.rot[k])) * PW'($signed(item_q.rot[j][k]));
        end
      end
    end
  end

  // Stage 1: products with the upper and lower halves of each diffusivity.
  logic signed [PartW-1:0] hp_q [3][3];
  logic signed [PartW-1:0] lp_q [3][3];

  always_ff @(posedge clk_i) begin
    if (stg_rdy[1]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          hp_q[j][k] <= PartW'(p_q[j][k]) *
                        PartW'($signed({1'b0, diff_i[k][DiffW-1:FracW]}));
          lp_q[j][k] <= PartW'(p_q[j][k]) *
                        PartW'($signed({1'b0, diff_i[k][FracW-1:0]}));
        end
      end
    end
  end

  // Stage 2: sums over the three axes.
  logic signed [SumW-1:0] hs_q [3];
  logic signed [SumW-1:0] ls_q [3];

  always_ff @(posedge clk_i) begin
    if (stg_rdy[2]) begin
      for (int j = 0; j < 3; j++) begin
        hs_q[j] <= SumW'(hp_q[j][0]) + SumW'(hp_q[j][1]) + SumW'(hp_q[j][2]);
        ls_q[j] <= SumW'(lp_q[j][0]) + SumW'(lp_q[j][1]) + SumW'(lp_q[j][2]);
      end
    end
  end

  // Stage 3: join the halves and round the Q32 sum to nearest, ties up.
  logic signed [TW-1:0] t_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [AccW-1:0] acc;
    if (stg_rdy[3]) begin
      for (int j = 0; j < 3; j++) begin
        acc = (AccW'(hs_q[j]) <<< FracW) + AccW'(ls_q[j]) + AccW'(RoundHalf);
        t_q[j] <= acc[AccW-1:2*FracW];
      end
    end
  end

  // Stage 4: saturation into the output register.
  logic [2:0][TenW-1:0] ten_q;

  always_ff @(posedge clk_i) begin
    if (stg_rdy[4]) begin
      for (int j = 0; j < 3; j++) begin
        if (t_q[j] > TW'(TenLimit)) begin
          ten_q[j] <= TenW'(TenLimit);
        end else if (t_q[j] < -TW'(TenLimit)) begin
          ten_q[j] <= -TenW'(TenLimit);
        end else begin
          ten_q[j] <= t_q[j][TenW-1:0];
        end
      end
    end
  end

  assign out_valid_o = vld_q[TenStg-1];
  assign out_meta_o  = meta_q[TenStg-1];
  assign out_ten_o   = ten_q;

  `RRT_ASSERT(a_load_when_free, (in_valid_i && in_ready_o) |-> (!busy_q || (row_q == ROW_LAST)), "matrix loaded over an unfinished one")
  `RRT_ASSERT(a_busy_mid_rows, (job_acc && (row_q != ROW_LAST)) |=> busy_q, "sequencer dropped a matrix before its last row")
  `RRT_ASSERT(a_tlast_row, out_valid_o |-> (out_meta_o.last_row == (out_meta_o.row == ROW_LAST)), "last row flag disagrees with row index")
  `RRT_ASSERT_NEVER(a_end_off_last, out_valid_o && out_meta_o.batch_end && !out_meta_o.last_row, "batch end outside a grain's last row")

endmodule

// ===== rtl/rodrigues_rotation_tensor.sv =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor: each accepted grain gives three row words, which
// leave on one stream in row order.
// Reset (rst_ni low, async) clears all valid bits, the row sequencer and
// diff_x, diff_y, diff_z to zero; cfg writes are taken in every cycle.
// ----------------------------------------------------------------------------
module rodrigues_rotation_tensor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Grain input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: rod_x[20:0], rod_y[41:21], rod_z[62:42], zero pad.
  input  logic [rrt_pkg::InTdataW-1:0]       s_axis_tdata,
  input  logic                               s_axis_tlast,   // last_grain
  // Row result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: row_index, rot_col0, rot_col1, rot_col2,
  // tensor_col0, tensor_col1, tensor_col2, zero pad.
  output logic [rrt_pkg::OutTdataW-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast,   // last_row
  output logic                               m_axis_tuser,   // batch_end
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rrt_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rrt_pkg::DiffW-1:0]          cfg_data_i
);
  import rrt_pkg::*;

  // The block is a pipeline of two parts. The rotation part forms the six
  // component products, the nine numerators and 1 + s, and then runs a
  // restoring divider that settles one quotient bit per stage, so the whole
  // rotation matrix of a grain is ready 21 stages after it enters. A word can
  // enter every cycle; each stage moves when it is empty or its successor
  // moves, so stalls compress bubbles and nothing is lost or repeated.
  //
  // The row sequencer then holds one matrix and hands out its three rows, one
  // per cycle unless the first tensor stage is stalled, to the tensor part:
  // products of rotation entries, products with the split diffusivities, sums,
  // rounding and saturation. The last tensor stage is the output register, and
  // earlier stages fill empty slots while a row waits for m_axis_tready.

  logic [2:0][DiffW-1:0] diff_q;

  // Writes go straight to the registers; an index past diff_z is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DIFF_X: diff_q[0] <= cfg_data_i;
        CFG_DIFF_Y: diff_q[1] <= cfg_data_i;
        CFG_DIFF_Z: diff_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic      rot_valid, rot_ready;
  rot_item_t rot_item;

  rrt_rot_pipe u_rot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .rod_x_i      ($signed(s_axis_tdata[RodW-1:0])),
    .rod_y_i      ($signed(s_axis_tdata[2*RodW-1:RodW])),
    .rod_z_i      ($signed(s_axis_tdata[3*RodW-1:2*RodW])),
    .last_grain_i (s_axis_tlast),
    .out_valid_o  (rot_valid),
    .out_ready_i  (rot_ready),
    .out_item_o   (rot_item)
  );

  row_meta_t            out_meta;
  logic [2:0][TenW-1:0] out_ten;

  rrt_tensor_pipe u_ten (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .in_item_i   (rot_item),
    .diff_i      (diff_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_meta_o  (out_meta),
    .out_ten_o   (out_ten)
  );

  // The row word is packed with the row index in the lowest bits.
  assign m_axis_tdata = {{(OutTdataW - OutBits){1'b0}},
                         out_ten[2], out_ten[1], out_ten[0],
                         out_meta.rot[2], out_meta.rot[1], out_meta.rot[0],
                         out_meta.row};
  assign m_axis_tlast = out_meta.last_row;
  assign m_axis_tuser = out_meta.batch_end;

endmodule

// ===== tb/rodrigues_rotation_tensor_test.sv =====
// ----------------------------------------------------------------------------
// Rodrigues rotation tensor testbench
// Streams grain vectors into the block and predicts the three row words of
// each grain in fixed point. Each arriving word is checked field by field.
// Sender and receiver idle at random. One phase stalls the output long enough
// to fill the pipeline, and another pauses the input until all rows are back.
// ----------------------------------------------------------------------------
module rodrigues_rotation_tensor_test;
  import rrt_pkg::*;

  // This index lies outside the register map. The block must ignore a write to it.
  localparam logic [CfgIdxW-1:0] CFG_NONE = 2'd3;
  localparam longint RotLim = 65536;
  localparam longint TenLim = 64'sd4294967295;

  typedef struct {
    logic [RowW-1:0]    row;
    logic [RotW-1:0]    rot [3];
    logic [TenW-1:0]    ten [3];
    logic               last_row;
    logic               batch_end;
  } row_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [DiffW-1:0]     cfg_data_i;

  // The testbench keeps its own copy of the diffusivity registers.
  logic [DiffW-1:0] diffusivity [3];
  row_word_t        pending_rows [$];
  int               error_count;
  bit               tx_quiet;
  bit               rx_quiet;
  int               rx_hold_cycles;

  rodrigues_rotation_tensor u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // This is the run limit. It is far beyond the slowest correct run.
  initial begin
    #3200000;
    $display("RESULT: ERROR");
    $finish;
  end

  // This is floor division for a positive divisor.
  function automatic longint div_floor(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // The function builds R and R*diag(D)*R^T for one grain and queues the
  // three row words that the block should send for it.
  function automatic void predict_rows(logic [RodW-1:0] rx, logic [RodW-1:0] ry,
                                       logic [RodW-1:0] rz, logic lg);
    longint    x, y, z, one, d, xx, yy, zz, xy, xz, yz;
    longint    num [3][3];
    longint    rot [3][3];
    longint    dv [3];
    longint    hi, lo, p, t;
    row_word_t w;
    x = longint'($signed(rx));
    y = longint'($signed(ry));
    z = longint'($signed(rz));
    one = 64'sd4294967296;
    xx = x * x; yy = y * y; zz = z * z;
    xy = x * y; xz = x * z; yz = y * z;
    d = one + xx + yy + zz;
    num[0][0] = one + xx - yy - zz;
    num[0][1] = 2 * (xy - z * 65536);
    num[0][2] = 2 * (xz + y * 65536);
    num[1][0] = 2 * (xy + z * 65536);
    num[1][1] = one - xx + yy - zz;
    num[1][2] = 2 * (yz - x * 65536);
    num[2][0] = 2 * (xz - y * 65536);
    num[2][1] = 2 * (yz + x * 65536);
    num[2][2] = one - xx - yy + zz;
    for (int i = 0; i < 3; i++) begin
      dv[i] = longint'({32'd0, diffusivity[i]});
      for (int j = 0; j < 3; j++)
        rot[i][j] = clamp_sym(div_floor(num[i][j] * 131072 + d, 2 * d), RotLim);
    end
    for (int i = 0; i < 3; i++) begin
      w.row = i[RowW-1:0];
      for (int j = 0; j < 3; j++) begin
        w.rot[j] = rot[i][j][RotW-1:0];
        hi = 0;
        lo = 0;
        // The diffusivity is split in halves so that the exact sum fits in 64 bits.
        for (int k = 0; k < 3; k++) begin
          p = rot[i][k] * rot[j][k];
          hi += p * (dv[k] >>> 16);
          lo += p * (dv[k] & 64'hFFFF);
        end
        hi += div_floor(lo, 65536);
        t = clamp_sym(div_floor(hi + 32768, 65536), TenLim);
        w.ten[j] = t[TenW-1:0];
      end
      w.last_row  = (i == 2);
      w.batch_end = (i == 2) ? lg : 1'b0;
      pending_rows.push_back(w);
    end
  endfunction

  // The sender offers one grain and waits until the block takes the word.
  // Valid stays high between grains unless a random gap is inserted.
  task automatic send_grain(logic [RodW-1:0] rx, logic [RodW-1:0] ry,
                            logic [RodW-1:0] rz, logic lg);
    if (!tx_quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, rz, ry, rx};
    s_axis_tlast  <= lg;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rows(rx, ry, rz, lg);
  endtask

  task automatic send_random_grain(bit wide);
    logic [RodW-1:0] c [3];
    for (int i = 0; i < 3; i++) begin
      if (wide) c[i] = RodW'($urandom_range(0, 21'h1FFFFF));
      else c[i] = RodW'($urandom_range(0, 262144) - 131072);
    end
    send_grain(c[0], c[1], c[2], $urandom_range(0, 3) == 0);
  endtask

  // The task blocks until every predicted row has arrived, then lets the pipe settle.
  task automatic drain_rows();
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DiffW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx != CFG_NONE) diffusivity[idx] = val;
  endtask

  task automatic set_diffusivity(logic [DiffW-1:0] dx, logic [DiffW-1:0] dy,
                                 logic [DiffW-1:0] dz);
    drain_rows();
    write_reg(CFG_DIFF_X, dx);
    write_reg(CFG_DIFF_Y, dy);
    write_reg(CFG_DIFF_Z, dz);
  endtask

  // This test covers the corner vectors: zero, the single axes, both ends of the
  // range and mixed signs. The batch end marker is both set and clear.
  task automatic test_directed();
    logic [RodW-1:0] maxv, minv, unit;
    maxv = 21'h0FFFFF;
    minv = 21'h100000;
    unit = 21'h010000;
    send_grain('0, '0, '0, 1'b0);
    send_grain('0, '0, '0, 1'b1);
    set_diffusivity(32'd1000, 32'd20000, 32'd300000);
    send_grain('0, '0, '0, 1'b0);
    send_grain(unit, '0, '0, 1'b0);
    send_grain('0, unit, '0, 1'b0);
    send_grain('0, '0, unit, 1'b1);
    send_grain(-unit, unit, -unit, 1'b0);
    send_grain(maxv, maxv, maxv, 1'b0);
    send_grain(minv, minv, minv, 1'b1);
    send_grain(maxv, minv, maxv, 1'b0);
    send_grain(minv, '0, maxv, 1'b0);
    send_grain(21'h000001, 21'h1FFFFF, 21'h000001, 1'b0);
    send_grain(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 1'b1);
    send_grain(21'h008000, 21'h004000, 21'h1FC000, 1'b0);
    send_grain(21'h0AAAAA, 21'h155555, 21'h0F0F0F, 1'b1);
  endtask

  // This test covers the register extremes, including saturation of tensor
  // entries at full scale. A write to the unmapped index must leave the
  // registers unchanged.
  task automatic test_register_extremes();
    set_diffusivity('1, '1, '1);
    for (int i = 0; i < 6; i++) send_random_grain(i[0]);
    send_grain(21'h00B505, '0, '0, 1'b0);
    set_diffusivity('1, '0, 32'h0001_0000);
    for (int i = 0; i < 6; i++) send_random_grain(i[0]);
    drain_rows();
    write_reg(CFG_NONE, 32'hDEAD_BEEF);
    for (int i = 0; i < 4; i++) send_random_grain(1'b0);
    set_diffusivity(32'h0000_FFFF, 32'h0001_0000, 32'h8000_0000);
    for (int i = 0; i < 6; i++) send_random_grain(i[0]);
  endtask

  task automatic test_random_grains(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        set_diffusivity($urandom, $urandom, $urandom_range(0, 32'h00FF_FFFF));
      send_random_grain($urandom_range(0, 3) == 0);
    end
  endtask

  // The output is held off for a long stretch while the sender keeps offering
  // grains, so the pipeline fills and input ready drops. Afterward the sender
  // stops until every row is back before it sends again.
  task automatic test_backpressure();
    drain_rows();
    rx_hold_cycles = 300;
    for (int i = 0; i < 30; i++) send_random_grain(1'b0);
    drain_rows();
    for (int i = 0; i < 5; i++) send_random_grain(1'b1);
  endtask

  // This is the receiver. Ready drops in random bursts, or for a long hold when
  // the backpressure test requests one. The hold is counted here in cycles.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  // Each accepted row word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    row_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      {got.ten[2], got.ten[1], got.ten[0], got.rot[2], got.rot[1], got.rot[0],
       got.row} = m_axis_tdata[OutBits-1:0];
      got.last_row  = m_axis_tlast;
      got.batch_end = m_axis_tuser;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row word %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_rows.pop_front();
        if (got.row !== want.row) begin
          $display("%0t: row_index exp %0d got %0d", $time, want.row, got.row);
          error_count++;
        end
        for (int j = 0; j < 3; j++) begin
          if (got.rot[j] !== want.rot[j]) begin
            $display("%0t: row %0d rot_col%0d exp %h got %h", $time, want.row, j,
                     want.rot[j], got.rot[j]);
            error_count++;
          end
          if (got.ten[j] !== want.ten[j]) begin
            $display("%0t: row %0d tensor_col%0d exp %h got %h", $time, want.row, j,
                     want.ten[j], got.ten[j]);
            error_count++;
          end
        end
        if (got.last_row !== want.last_row) begin
          $display("%0t: last_row exp %b got %b", $time, want.last_row, got.last_row);
          error_count++;
        end
        if (got.batch_end !== want.batch_end) begin
          $display("%0t: batch_end exp %b got %b", $time, want.batch_end,
                   got.batch_end);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count    = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;
    rx_hold_cycles = 0;
    for (int i = 0; i < 3; i++) diffusivity[i] = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_DIFF_X;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_grains(50);
    // In the last stretch, neither side idles.
    drain_rows();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_grains(40);

    drain_rows();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
